// ----- sv/sfpc_pkg.sv -----
package sfpc_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 26;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_RA  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_DEC = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RA_SCALE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_FIELD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_GAIN     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_GAIN     = 3'd5;

    // reset values
    localparam logic [15:0] RA_SCALE_RESET = 16'd32768;

    // pixel saturation
    localparam logic [9:0] PIX_MAX = 10'd1023;

    // magnitude thresholds in tenths
    localparam logic signed [7:0] MAG_BRIGHT = 8'sd10;
    localparam logic signed [7:0] MAG_RED24  = 8'sd20;
    localparam logic signed [7:0] MAG_RAD1   = 8'sd28;
    localparam logic signed [7:0] MAG_RED18  = 8'sd30;
    localparam logic signed [7:0] MAG_RED13  = 8'sd40;

    // red levels of the RGB565 colour
    localparam logic [4:0] RED_31 = 5'd31;
    localparam logic [4:0] RED_24 = 5'd24;
    localparam logic [4:0] RED_18 = 5'd18;
    localparam logic [4:0] RED_13 = 5'd13;
    localparam logic [4:0] RED_8  = 5'd8;

    // dot radius codes
    localparam logic [1:0] RADIUS_PIXEL = 2'd0;
    localparam logic [1:0] RADIUS_ONE   = 2'd1;
    localparam logic [1:0] RADIUS_TWO   = 2'd2;

    typedef struct packed {
        logic [15:0]        star_ra;
        logic signed [15:0] star_dec;
        logic signed [7:0]  star_mag;
    } star_in_t;

    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [15:0] colour;
        logic [1:0]  dot_radius;
    } star_out_t;

endpackage

// ----- sv/star_field_projection_cull.sv -----
// Star field projection and cull.
// Input channel in_valid/in_ready/in_data carries one catalog star per
// transfer; output channel out_valid/out_ready/out_data carries one pixel
// result for each star that falls inside the field (edges included).
// Stars outside the field, and all stars while half_field is zero, give
// no result. The configuration port (cfg_we, cfg_index, cfg_data) writes
// one register per cycle with no wait; indexes beyond the list are ignored.
// Write it only while the pipeline is empty.
// An accepted star passes through five register stages before its result
// shows on out_valid. Throughput: one star per cycle while out_ready is high,
// since every stage then hands its star on at each edge; the three
// multipliers sit in stages two to four, one in each.
// When out_ready is low, results hold in the output register and the stages
// behind it fill up; bubbles left by culled stars are squeezed out, and
// in_ready drops only once every stage holds a star.
// Reset clears all stage valid bits and puts the configuration registers at
// their reset values (ra_scale at 1.0, the others zero).
module star_field_projection_cull (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sfpc_pkg::star_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output sfpc_pkg::star_out_t              out_data
);

    // configuration registers
    logic [15:0]        center_ra_reg;
    logic signed [15:0] center_dec_reg;
    logic [15:0]        ra_scale_reg;
    logic [15:0]        half_field_reg;
    logic [25:0]        x_gain_reg;
    logic [25:0]        y_gain_reg;

    // stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: raw offsets
    logic signed [15:0] s1_d_reg,    s1_d_next;
    logic signed [16:0] s1_ddec_reg, s1_ddec_next;
    logic signed [7:0]  s1_mag_reg;

    // stage 2: scaled ra offset, dec offset terms
    logic signed [32:0] dra_prod;
    logic signed [33:0] s2_dra_reg,  s2_dra_next;
    logic [16:0]        s2_adec_reg, s2_adec_next;
    logic signed [17:0] s2_yoff_reg, s2_yoff_next;
    logic signed [7:0]  s2_mag_reg;

    // stage 3: cull, x offset, y product
    logic [33:0]        neg_dra;
    logic [32:0]        abs_dra;
    logic               keep;
    logic signed [33:0] xoff_full;
    logic [42:0]        y_prod;
    logic [32:0]        s3_xoff_reg;
    logic [26:0]        s3_yraw_reg;
    logic signed [7:0]  s3_mag_reg;

    // stage 4: x product
    logic [58:0]        x_prod;
    logic [27:0]        s4_xraw_reg;
    logic [26:0]        s4_yraw_reg;
    logic signed [7:0]  s4_mag_reg;

    // stage 5: saturation and grading
    sfpc_pkg::star_out_t out_reg, out_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_ra_reg  <= '0;
            center_dec_reg <= '0;
            ra_scale_reg   <= sfpc_pkg::RA_SCALE_RESET;
            half_field_reg <= '0;
            x_gain_reg     <= '0;
            y_gain_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfpc_pkg::CFG_CENTER_RA:  center_ra_reg  <= cfg_data[15:0];
                sfpc_pkg::CFG_CENTER_DEC: center_dec_reg <= $signed(cfg_data[15:0]);
                sfpc_pkg::CFG_RA_SCALE:   ra_scale_reg   <= cfg_data[15:0];
                sfpc_pkg::CFG_HALF_FIELD: half_field_reg <= cfg_data[15:0];
                sfpc_pkg::CFG_X_GAIN:     x_gain_reg     <= cfg_data;
                sfpc_pkg::CFG_Y_GAIN:     y_gain_reg     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // a stage loads when it is empty or the stage after it loads
    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1 logic: wrapped ra difference and dec difference
    always_comb
    begin
        s1_d_next    = $signed(in_data.star_ra - center_ra_reg);
        s1_ddec_next = $signed({in_data.star_dec[15], in_data.star_dec})
                     - $signed({center_dec_reg[15], center_dec_reg});
    end

    // stage 2 logic: dra_q = 2 * d * ra_scale, |ddec| and half - ddec
    always_comb
    begin
        dra_prod     = s1_d_reg * $signed({1'b0, ra_scale_reg});
        s2_dra_next  = {dra_prod, 1'b0};
        s2_adec_next = s1_ddec_reg[16] ? (~s1_ddec_reg + 17'd1) : s1_ddec_reg;
        s2_yoff_next = $signed({2'b00, half_field_reg})
                     - $signed({s1_ddec_reg[16], s1_ddec_reg});
    end

    // stage 3 logic: edge test, x offset and row product
    always_comb
    begin
        neg_dra   = ~s2_dra_reg + 34'd1;
        abs_dra   = s2_dra_reg[33] ? neg_dra[32:0] : s2_dra_reg[32:0];
        keep      = (abs_dra <= {2'b00, half_field_reg, 15'b0})
                 && (s2_adec_reg <= {1'b0, half_field_reg});
        xoff_full = s2_dra_reg + $signed({3'b000, half_field_reg, 15'b0});
        y_prod    = s2_yoff_reg[16:0] * y_gain_reg;
    end

    // stage 4 logic: column product
    assign x_prod = s3_xoff_reg * x_gain_reg;

    // stage 5 logic: one plus floor with saturation, magnitude grading
    always_comb
    begin
        out_next = '0;
        if (s4_xraw_reg >= {18'd0, sfpc_pkg::PIX_MAX})
            out_next.pixel_x = sfpc_pkg::PIX_MAX;
        else
            out_next.pixel_x = s4_xraw_reg[9:0] + 10'd1;
        if (s4_yraw_reg >= {17'd0, sfpc_pkg::PIX_MAX})
            out_next.pixel_y = sfpc_pkg::PIX_MAX;
        else
            out_next.pixel_y = s4_yraw_reg[9:0] + 10'd1;

        priority if (s4_mag_reg <= sfpc_pkg::MAG_BRIGHT)
            out_next.colour = {sfpc_pkg::RED_31, 11'd0};
        else if (s4_mag_reg <= sfpc_pkg::MAG_RED24)
            out_next.colour = {sfpc_pkg::RED_24, 11'd0};
        else if (s4_mag_reg <= sfpc_pkg::MAG_RED18)
            out_next.colour = {sfpc_pkg::RED_18, 11'd0};
        else if (s4_mag_reg <= sfpc_pkg::MAG_RED13)
            out_next.colour = {sfpc_pkg::RED_13, 11'd0};
        else
            out_next.colour = {sfpc_pkg::RED_8, 11'd0};

        priority if (s4_mag_reg <= sfpc_pkg::MAG_BRIGHT)
            out_next.dot_radius = sfpc_pkg::RADIUS_TWO;
        else if (s4_mag_reg <= sfpc_pkg::MAG_RAD1)
            out_next.dot_radius = sfpc_pkg::RADIUS_ONE;
        else
            out_next.dot_radius = sfpc_pkg::RADIUS_PIXEL;
    end

    // valid bits; a zero half field or a culled star leaves a bubble
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid && (half_field_reg != 16'd0);
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg && keep;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_d_reg    <= s1_d_next;
            s1_ddec_reg <= s1_ddec_next;
            s1_mag_reg  <= in_data.star_mag;
        end
        if (rdy2)
        begin
            s2_dra_reg  <= s2_dra_next;
            s2_adec_reg <= s2_adec_next;
            s2_yoff_reg <= s2_yoff_next;
            s2_mag_reg  <= s1_mag_reg;
        end
        if (rdy3)
        begin
            s3_xoff_reg <= xoff_full[32:0];
            s3_yraw_reg <= y_prod[42:16];
            s3_mag_reg  <= s2_mag_reg;
        end
        if (rdy4)
        begin
            s4_xraw_reg <= x_prod[58:31];
            s4_yraw_reg <= s3_yraw_reg;
            s4_mag_reg  <= s3_mag_reg;
        end
        if (rdy5)
            out_reg <= out_next;
    end

    assign out_valid = v5_reg;
    assign out_data  = out_reg;

endmodule
